FILE: rtl/mse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_pkg
// Shared constants and control types for the merge sort engine.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam int MSE_DATA_W    = 32;
    localparam int MSE_MAX_ITEMS = 64;

    // Source of the bank write data
    typedef enum logic [1:0] {
        WR_IN = 2'd0,   // incoming stream value
        WR_A  = 2'd1,   // head of left run
        WR_B  = 2'd2    // head of right run
    } wr_src_t;

    typedef struct packed {
        logic    wr_en;
        wr_src_t wr_src;
        logic    wr_bank;
        logic    src_bank;
    } mse_cmd_t;

endpackage
`default_nettype wire

FILE: rtl/mse_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_datapath
// Two ping-pong storage banks with two registered read ports each, the
// write-data select and the signed compare of the two run heads.
// ----------------------------------------------------------------------------
module mse_datapath import mse_pkg::*; #(
    parameter int MAX_ITEMS = MSE_MAX_ITEMS
) (
    input  wire logic                          aclk,
    input  wire mse_cmd_t                      cmd,
    input  wire logic [$clog2(MAX_ITEMS)-1:0]  wr_addr,
    input  wire logic [$clog2(MAX_ITEMS)-1:0]  rd_addr_a,
    input  wire logic [$clog2(MAX_ITEMS)-1:0]  rd_addr_b,
    input  wire logic [MSE_DATA_W-1:0]         in_value,
    output logic      [MSE_DATA_W-1:0]         rd_a,
    output logic                               le_ab
);

    logic [MSE_DATA_W-1:0] bank0_reg [0:MAX_ITEMS-1];
    logic [MSE_DATA_W-1:0] bank1_reg [0:MAX_ITEMS-1];
    logic [MSE_DATA_W-1:0] b0_a_reg, b0_b_reg, b1_a_reg, b1_b_reg;
    logic [MSE_DATA_W-1:0] rd_b;
    logic [MSE_DATA_W-1:0] wr_data;

    always_comb begin
        rd_a  = cmd.src_bank ? b1_a_reg : b0_a_reg;
        rd_b  = cmd.src_bank ? b1_b_reg : b0_b_reg;
        le_ab = ($signed(rd_a) <= $signed(rd_b));
        unique case (cmd.wr_src)
            WR_IN:   wr_data = in_value;
            WR_A:    wr_data = rd_a;
            WR_B:    wr_data = rd_b;
            default: wr_data = rd_a;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !cmd.wr_bank) begin
            bank0_reg[wr_addr] <= wr_data;
        end
        b0_a_reg <= bank0_reg[rd_addr_a];
        b0_b_reg <= bank0_reg[rd_addr_b];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && cmd.wr_bank) begin
            bank1_reg[wr_addr] <= wr_data;
        end
        b1_a_reg <= bank1_reg[rd_addr_a];
        b1_b_reg <= bank1_reg[rd_addr_b];
    end

endmodule
`default_nettype wire

FILE: rtl/mse_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: load, bottom-up merge passes between the two banks, drain.
// ----------------------------------------------------------------------------
module mse_ctrl import mse_pkg::*; #(
    parameter int MAX_ITEMS = MSE_MAX_ITEMS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic                               m_tlast,
    output logic                               m_overflow,
    input  wire logic                          le_ab,
    output mse_cmd_t                           cmd,
    output logic      [$clog2(MAX_ITEMS)-1:0]  wr_addr,
    output logic      [$clog2(MAX_ITEMS)-1:0]  rd_addr_a,
    output logic      [$clog2(MAX_ITEMS)-1:0]  rd_addr_b
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SEG   = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           ovf_reg, ovf_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [PW-1:0]  width_reg, width_next;
    logic [PW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  a_reg, a_next;
    logic [CW-1:0]  b_reg, b_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           src_reg, src_next;

    logic [PW-1:0]  n_ext;
    logic [PW-1:0]  mid_sum, hi_sum;
    logic           not_full;
    logic           take_a;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        src_next   = src_reg;

        cmd.wr_en    = 1'b0;
        cmd.wr_src   = WR_IN;
        cmd.wr_bank  = 1'b0;
        cmd.src_bank = src_reg;
        wr_addr      = fill_reg[AW-1:0];

        n_ext    = PW'(n_reg);
        mid_sum  = lo_reg + width_reg;
        hi_sum   = lo_reg + (width_reg << 1);
        not_full = (fill_reg < CW'(MAX_ITEMS));
        take_a   = (a_reg < mid_reg) && ((b_reg >= hi_reg) || le_ab);

        s_tready   = state_reg == S_LOAD;
        m_tvalid   = state_reg == S_OUT;
        m_tlast    = (a_reg == CW'(n_reg - CW'(1)));
        m_overflow = ovf_reg;

        unique case (state_reg)
            S_LOAD: begin
                if (s_tvalid) begin
                    if (not_full) begin
                        cmd.wr_en = 1'b1;
                        fill_next = CW'(fill_reg + CW'(1));
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        n_next     = not_full ? CW'(fill_reg + CW'(1)) : fill_reg;
                        width_next = PW'(1);
                        lo_next    = '0;
                        src_next   = 1'b0;
                        state_next = S_SEG;
                    end
                end
            end
            S_SEG: begin
                if (width_reg >= n_ext) begin
                    a_next     = '0;
                    state_next = S_OUT;
                end else if (lo_reg >= n_ext) begin
                    // pass complete, swap banks
                    width_next = width_reg << 1;
                    lo_next    = '0;
                    src_next   = ~src_reg;
                end else begin
                    mid_next   = (mid_sum > n_ext) ? n_reg : mid_sum[CW-1:0];
                    hi_next    = (hi_sum > n_ext) ? n_reg : hi_sum[CW-1:0];
                    a_next     = lo_reg[CW-1:0];
                    b_next     = mid_next;
                    k_next     = lo_reg[CW-1:0];
                    state_next = S_MERGE;
                end
            end
            S_MERGE: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_bank = ~src_reg;
                cmd.wr_src  = take_a ? WR_A : WR_B;
                wr_addr     = k_reg[AW-1:0];
                if (take_a) begin
                    a_next = CW'(a_reg + CW'(1));
                end else begin
                    b_next = CW'(b_reg + CW'(1));
                end
                k_next = CW'(k_reg + CW'(1));
                if (k_next == hi_reg) begin
                    lo_next    = PW'(hi_reg);
                    state_next = S_SEG;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    if (m_tlast) begin
                        fill_next  = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end else begin
                        a_next = CW'(a_reg + CW'(1));
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        rd_addr_a = a_next[AW-1:0];
        rd_addr_b = b_next[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        k_reg     <= k_next;
        src_reg   <= src_next;
    end

endmodule
`default_nettype wire

FILE: rtl/merge_sort_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// merge_sort_engine
// Stable ascending sorter for sets of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one value per transfer, s_tlast closes the set. Values past
//   MAX_ITEMS are dropped and the set is flagged as overflowed.
//   Master channel: the sorted set, one value per transfer, m_tlast on the
//   largest value, m_tuser = overflow flag on every transfer of the set.
// Sequence:
//   Load: values are accepted back to back. Sort: ceil(log2(n)) passes,
//   each a setup step per run pair with every value written once through
//   the single bank write port, then a bank swap; a final step starts the
//   drain. Drain: values leave back to back while m_tready is high.
//   s_tready is low from the closing transfer until the last sorted value
//   has been taken; a new set can start in the cycle after that.
// Stalls: m_tready low holds the current result stable; nothing is lost.
// Reset: synchronous aresetn, empties the set and returns to loading.
// ----------------------------------------------------------------------------
module merge_sort_engine import mse_pkg::*; #(
    parameter int MAX_ITEMS = MSE_MAX_ITEMS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [MSE_DATA_W-1:0]  s_tdata,   // [31:0] value
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [MSE_DATA_W-1:0]  m_tdata,   // [31:0] sorted_value
    output logic                        m_tlast,
    output logic                        m_tuser    // [0] overflow
);

    localparam int AW = $clog2(MAX_ITEMS);

    mse_cmd_t       cmd;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr_a;
    logic [AW-1:0]  rd_addr_b;
    logic           le_ab;

    mse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tlast    (s_tlast),
        .s_tready   (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .m_overflow (m_tuser),
        .le_ab      (le_ab),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b)
    );

    mse_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk      (aclk),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .in_value  (s_tdata),
        .rd_a      (m_tdata),
        .le_ab     (le_ab)
    );

    a_phases_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_tvalid && s_tready))
        else $error("load and drain active together");

    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("engine not back to loading after final result");

    a_drain_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && $stable(m_tuser))
        else $error("drain broke off or overflow flag changed within a set");

endmodule
`default_nettype wire
